@@ sv/lzsd_pkg.sv @@
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants of the LZSS decompressor: window size, match
// length offset and the codes of the compressed-stream parser.
// ----------------------------------------------------------------------------
package lzsd_pkg;

  // Default history window size in bytes.
  localparam int unsigned WindowSizeDef = 4096;

  // Shortest match; the length nibble counts from here.
  localparam int unsigned MinMatch = 3;

  // Distance of the reset write position below the window end.
  localparam int unsigned StartGap = 18;

  // Parser phase codes.
  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_ITEM = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  // One data byte on either channel.
  typedef logic [7:0] byte_t;

endpackage

@@ sv/lzsd_in_if.sv @@
// ----------------------------------------------------------------------------
// lzsd_in_if
// Compressed byte channel: valid/ready handshake with one byte and an
// end-of-stream mark per item.
// ----------------------------------------------------------------------------
interface lzsd_in_if;
  logic           valid;
  logic           ready;
  lzsd_pkg::byte_t in_byte;
  logic           in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

@@ sv/lzsd_out_if.sv @@
// ----------------------------------------------------------------------------
// lzsd_out_if
// Decompressed byte channel: valid/ready handshake with one byte and the
// run and stream end marks per item.
// ----------------------------------------------------------------------------
interface lzsd_out_if;
  logic           valid;
  logic           ready;
  lzsd_pkg::byte_t out_byte;
  logic           run_last;
  logic           stream_end;

  modport source (output valid, output out_byte, output run_last, output stream_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_end,
                  output ready);
endinterface

@@ sv/lzss_decompressor.sv @@
// ----------------------------------------------------------------------------
// lzss_decompressor
// LZSS decoder over a WINDOW_SIZE-byte (default 4096) history window in sync RAM.
// Flag, literal and pair bytes are parsed one item at a time; a pair copies
// 3 to 18 bytes out of the window, writing each back as it is emitted.
// ----------------------------------------------------------------------------
// Timing: a literal appears at the output in the cycle after it is accepted; a
//   match's first byte passes the registered window read, then the output register.
// Flow: flag and pair bytes are taken when no match is copying, a literal only
//   if output is free; match bytes are paced by the single window read port.
// Reset: the window reads as zero until written, tracked by a fill count, so
//   there is no clearing pass and the block is ready right after reset.
module lzss_decompressor #(
  parameter int unsigned WINDOW_SIZE = lzsd_pkg::WindowSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzsd_in_if.sink     in_i,
  lzsd_out_if.source  out_o
);
  import lzsd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam logic [AW-1:0] WpReset = AW'(WINDOW_SIZE - StartGap);

  // Sequencer states.
  localparam logic ST_PARSE = 1'b0;
  localparam logic ST_COPY  = 1'b1;

  // Control registers.
  logic          st_q, st_d;
  logic [1:0]    phase_q, phase_d;
  logic [8:0]    flag_q, flag_d;
  logic [AW-1:0] wp_q;
  logic [AW:0]   fill_q;
  logic [4:0]    rem_q, rem_d;
  logic          last_q, last_d;
  byte_t         low_q, low_d;

  // Window memory and its read side.
  byte_t         win_q [WINDOW_SIZE];
  byte_t         rd_data_q;
  logic [AW-1:0] rd_addr, rd_addr_q;
  logic          rd_valid_q;
  logic          fwd_hit_q;
  byte_t         fwd_data_q;
  logic [AW-1:0] rd_off;

  // Output register.
  logic          ovalid_q;
  byte_t         obyte_q;
  logic          orun_q;
  logic          oend_q;

  logic          out_free;
  logic          is_lit;
  logic          in_fire;
  logic          hb_fire;
  logic          cp_fire;
  byte_t         cp_data;
  logic          wr_en;
  byte_t         wr_data;
  logic [8:0]    flag_nxt;
  logic [1:0]    phase_done;

  // Handshake and item classification.
  assign out_free = !ovalid_q || out_o.ready;
  assign is_lit   = (phase_q == PH_ITEM) && flag_q[0];
  assign in_i.ready = (st_q == ST_PARSE) && (out_free || !is_lit);
  assign in_fire  = in_i.valid && in_i.ready;
  assign hb_fire  = in_fire && (phase_q == PH_HIGH);
  assign cp_fire  = (st_q == ST_COPY) && out_free;

  // Copied byte: forwarded write, stored byte, or zero for an unwritten entry.
  assign cp_data = fwd_hit_q ? fwd_data_q : (rd_valid_q ? rd_data_q : 8'h00);

  // Window write: copied bytes and literals.
  assign wr_en   = cp_fire || (in_fire && is_lit);
  assign wr_data = cp_fire ? cp_data : in_i.in_byte;

  // Read address: start of a match, next byte, or a repeat while stalled.
  always_comb begin
    if (hb_fire) begin
      rd_addr = AW'({in_i.in_byte[7:4], low_q});
    end else if (cp_fire) begin
      rd_addr = rd_addr_q + AW'(1);
    end else begin
      rd_addr = rd_addr_q;
    end
  end

  assign rd_off = rd_addr - WpReset;

  // Flag shift after one item is finished.
  assign flag_nxt   = flag_q >> 1;
  assign phase_done = (flag_nxt <= 9'd1) ? PH_FLAG : PH_ITEM;

  // Parser and sequencer next state.
  always_comb begin
    st_d    = st_q;
    phase_d = phase_q;
    flag_d  = flag_q;
    rem_d   = rem_q;
    last_d  = last_q;
    low_d   = low_q;
    if (in_fire) begin
      case (phase_q)
        PH_ITEM: begin
          if (flag_q[0]) begin
            flag_d  = flag_nxt;
            phase_d = phase_done;
          end else begin
            low_d   = in_i.in_byte;
            phase_d = PH_HIGH;
          end
        end
        PH_HIGH: begin
          flag_d  = flag_nxt;
          phase_d = phase_done;
          rem_d   = 5'(in_i.in_byte[3:0]) + 5'(MinMatch);
          last_d  = in_i.in_last;
          st_d    = ST_COPY;
        end
        default: begin
          flag_d  = {1'b1, in_i.in_byte};
          phase_d = PH_ITEM;
        end
      endcase
    end
    if (cp_fire) begin
      rem_d = rem_q - 5'd1;
      if (rem_q == 5'd1) begin
        st_d = ST_PARSE;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_PARSE;
      phase_q <= PH_FLAG;
      flag_q  <= '0;
      rem_q   <= '0;
      last_q  <= 1'b0;
      low_q   <= '0;
      wp_q    <= WpReset;
      fill_q  <= '0;
    end else begin
      st_q    <= st_d;
      phase_q <= phase_d;
      flag_q  <= flag_d;
      rem_q   <= rem_d;
      last_q  <= last_d;
      low_q   <= low_d;
      if (wr_en) begin
        wp_q <= wp_q + AW'(1);
        if (!fill_q[AW]) begin
          fill_q <= fill_q + (AW+1)'(1);
        end
      end
    end
  end

  // Window memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_q[wp_q] <= wr_data;
    end
    rd_data_q <= win_q[rd_addr];
  end

  // Read tracking: address, written-entry check and same-cycle forwarding.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q  <= '0;
      rd_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      rd_addr_q  <= rd_addr;
      rd_valid_q <= fill_q[AW] || (rd_off < fill_q[AW-1:0]);
      fwd_hit_q  <= wr_en && (rd_addr == wp_q);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cp_fire || (in_fire && is_lit)) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cp_fire) begin
      obyte_q <= cp_data;
      orun_q  <= (rem_q == 5'd1);
      oend_q  <= (rem_q == 5'd1) && last_q;
    end else if (in_fire && is_lit) begin
      obyte_q <= in_i.in_byte;
      orun_q  <= 1'b1;
      oend_q  <= in_i.in_last;
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.out_byte   = obyte_q;
  assign out_o.run_last   = orun_q;
  assign out_o.stream_end = oend_q;

endmodule
